[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
// Both macros use the clk and rst_n of the module they stand in.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

[hdl/sfcs_pkg.sv]
// ---------------------------------------------------------------------------
// sfcs_pkg
// Types, opcodes and field widths of the SPI flash command sequencer.
// ---------------------------------------------------------------------------
package sfcs_pkg;

  localparam int ADDR_W  = 24;
  localparam int LEN_W   = 25;
  localparam int OP_W    = 3;
  localparam int MAX_RES = 7;
  localparam int CNT_W   = 3;

  // host-side operations
  localparam logic [OP_W-1:0] OP_READ  = 3'd0;
  localparam logic [OP_W-1:0] OP_PROG  = 3'd1;
  localparam logic [OP_W-1:0] OP_SECT  = 3'd2;
  localparam logic [OP_W-1:0] OP_CHIP  = 3'd3;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd4;
  localparam logic [OP_W-1:0] OP_REPLY = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_SPI    = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  // sequencer phase
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_READ = 2'd1;
  localparam logic [1:0] PH_PROG = 2'd2;
  localparam logic [1:0] PH_POLL = 2'd3;

  // active command
  localparam logic [1:0] CMD_READ = 2'd0;
  localparam logic [1:0] CMD_PROG = 2'd1;
  localparam logic [1:0] CMD_SECT = 2'd2;
  localparam logic [1:0] CMD_CHIP = 2'd3;

  // flash opcodes
  localparam logic [7:0] SPI_WREN  = 8'h06;
  localparam logic [7:0] SPI_PP    = 8'h02;
  localparam logic [7:0] SPI_RDSR  = 8'h05;
  localparam logic [7:0] SPI_READ  = 8'h03;
  localparam logic [7:0] SPI_SE    = 8'hD8;
  localparam logic [7:0] SPI_CE    = 8'h60;
  localparam logic [7:0] SPI_DUMMY = 8'h00;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [7:0]        data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       release_select;
    logic       wants_reply;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic [1:0]        active_command;
    logic [ADDR_W-1:0] page_address;
    logic [LEN_W-1:0]  bytes_left;
  } ctl_t;

  function automatic res_t spi_word(input logic [7:0] val, input logic rel,
                                    input logic rep);
    res_t r;
    r.kind           = KIND_SPI;
    r.byte_value     = val;
    r.release_select = rel;
    r.wants_reply    = rep;
    r.last           = 1'b0;
    return r;
  endfunction

  function automatic res_t mark_word(input logic [1:0] kind, input logic [7:0] val);
    res_t r;
    r.kind           = kind;
    r.byte_value     = val;
    r.release_select = 1'b0;
    r.wants_reply    = 1'b0;
    r.last           = 1'b0;
    return r;
  endfunction

endpackage

[hdl/sfcs_in_if.sv]
// ---------------------------------------------------------------------------
// sfcs_in_if
// Input channel: host commands, host write bytes and link reply bytes.
// ---------------------------------------------------------------------------
interface sfcs_in_if;
  import sfcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  length;
  logic [7:0]        data_byte;

  modport source (output valid, output operation, output address, output length,
                  output data_byte, input ready);
  modport sink (input valid, input operation, input address, input length,
                input data_byte, output ready);
endinterface

[hdl/sfcs_out_if.sv]
// ---------------------------------------------------------------------------
// sfcs_out_if
// Result channel: SPI bytes with select/reply marks, read data, done, reject.
// ---------------------------------------------------------------------------
interface sfcs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic       release_select;
  logic       wants_reply;
  logic       last;

  modport source (output valid, output kind, output byte_value, output release_select,
                  output wants_reply, output last, input ready);
  modport sink (input valid, input kind, input byte_value, input release_select,
                input wants_reply, input last, output ready);
endinterface

[hdl/sfcs_step.sv]
// ---------------------------------------------------------------------------
// sfcs_step
// Decode of one word against the sequencer state: next state and the
// list of result words it produces.
// ---------------------------------------------------------------------------
module sfcs_step #(
  parameter int PAGE_BYTES   = 256,
  parameter int ADDRESS_BITS = 24,
  parameter int PFW          = $clog2(PAGE_BYTES) + 1
) (
  input  sfcs_pkg::item_t             item,
  input  sfcs_pkg::ctl_t              ctl,
  input  logic [PFW-1:0]              page_fill,
  output sfcs_pkg::ctl_t              ctl_nxt,
  output logic [PFW-1:0]              page_fill_nxt,
  output sfcs_pkg::res_t              results [sfcs_pkg::MAX_RES],
  output logic [sfcs_pkg::CNT_W-1:0]  res_cnt
);
  import sfcs_pkg::*;

  localparam int AW = (ADDRESS_BITS >= ADDR_W) ? ADDR_W : ADDRESS_BITS;
  localparam logic [ADDR_W-1:0] AMASK = {ADDR_W{1'b1}} >> (ADDR_W - AW);

  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] next_page;
  logic [LEN_W-1:0]  bl_dec;
  logic [PFW-1:0]    pf_inc;
  logic              len_zero;
  logic              len_one;
  res_t              raw [MAX_RES];

  assign addr      = item.address & AMASK;
  assign next_page = (ctl.page_address + ADDR_W'(PAGE_BYTES)) & AMASK;
  assign bl_dec    = ctl.bytes_left - LEN_W'(1);
  assign pf_inc    = page_fill + PFW'(1);
  assign len_zero  = (item.length == '0);
  assign len_one   = (item.length == LEN_W'(1));

  always_comb begin
    ctl_nxt       = ctl;
    page_fill_nxt = page_fill;
    for (int i = 0; i < MAX_RES; i++) begin
      raw[i] = mark_word(KIND_REJECT, 8'h00);
    end
    res_cnt = CNT_W'(1);

    case (ctl.phase)
      PH_IDLE: begin
        case (item.operation)
          OP_READ: begin
            ctl_nxt.active_command = CMD_READ;
            raw[0]  = spi_word(SPI_READ, 1'b0, 1'b0);
            raw[1]  = spi_word(addr[23:16], 1'b0, 1'b0);
            raw[2]  = spi_word(addr[15:8], 1'b0, 1'b0);
            raw[3]  = spi_word(addr[7:0], len_zero, 1'b0);
            res_cnt = CNT_W'(5);
            if (len_zero) begin
              raw[4] = mark_word(KIND_DONE, 8'h00);
            end else begin
              raw[4]                 = spi_word(SPI_DUMMY, len_one, 1'b1);
              ctl_nxt.bytes_left     = item.length;
              ctl_nxt.phase          = PH_READ;
            end
          end
          OP_PROG: begin
            ctl_nxt.active_command = CMD_PROG;
            if (len_zero) begin
              raw[0] = mark_word(KIND_DONE, 8'h00);
            end else begin
              ctl_nxt.page_address = addr;
              ctl_nxt.bytes_left   = item.length;
              ctl_nxt.phase        = PH_PROG;
              page_fill_nxt        = '0;
              raw[0]  = spi_word(SPI_WREN, 1'b1, 1'b0);
              raw[1]  = spi_word(SPI_PP, 1'b0, 1'b0);
              raw[2]  = spi_word(addr[23:16], 1'b0, 1'b0);
              raw[3]  = spi_word(addr[15:8], 1'b0, 1'b0);
              raw[4]  = spi_word(addr[7:0], 1'b0, 1'b0);
              res_cnt = CNT_W'(5);
            end
          end
          OP_SECT: begin
            ctl_nxt.active_command = CMD_SECT;
            ctl_nxt.phase          = PH_POLL;
            raw[0]  = spi_word(SPI_WREN, 1'b1, 1'b0);
            raw[1]  = spi_word(SPI_SE, 1'b0, 1'b0);
            raw[2]  = spi_word(addr[23:16], 1'b0, 1'b0);
            raw[3]  = spi_word(addr[15:8], 1'b0, 1'b0);
            raw[4]  = spi_word(addr[7:0], 1'b1, 1'b0);
            raw[5]  = spi_word(SPI_RDSR, 1'b0, 1'b0);
            raw[6]  = spi_word(SPI_DUMMY, 1'b1, 1'b1);
            res_cnt = CNT_W'(7);
          end
          OP_CHIP: begin
            ctl_nxt.active_command = CMD_CHIP;
            ctl_nxt.phase          = PH_POLL;
            raw[0]  = spi_word(SPI_WREN, 1'b1, 1'b0);
            raw[1]  = spi_word(SPI_CE, 1'b1, 1'b0);
            raw[2]  = spi_word(SPI_RDSR, 1'b0, 1'b0);
            raw[3]  = spi_word(SPI_DUMMY, 1'b1, 1'b1);
            res_cnt = CNT_W'(4);
          end
          default: ;
        endcase
      end
      PH_READ: begin
        if (item.operation == OP_REPLY) begin
          ctl_nxt.bytes_left = bl_dec;
          raw[0]  = mark_word(KIND_DATA, item.data_byte);
          res_cnt = CNT_W'(2);
          if (bl_dec != '0) begin
            raw[1] = spi_word(SPI_DUMMY, bl_dec == LEN_W'(1), 1'b1);
          end else begin
            raw[1]        = mark_word(KIND_DONE, 8'h00);
            ctl_nxt.phase = PH_IDLE;
          end
        end
      end
      PH_PROG: begin
        if (item.operation == OP_WRITE) begin
          page_fill_nxt      = pf_inc;
          ctl_nxt.bytes_left = bl_dec;
          // page full or data exhausted: close the page and poll
          if (pf_inc >= PFW'(PAGE_BYTES) || bl_dec == '0) begin
            raw[0]        = spi_word(item.data_byte, 1'b1, 1'b0);
            raw[1]        = spi_word(SPI_RDSR, 1'b0, 1'b0);
            raw[2]        = spi_word(SPI_DUMMY, 1'b1, 1'b1);
            res_cnt       = CNT_W'(3);
            ctl_nxt.phase = PH_POLL;
          end else begin
            raw[0] = spi_word(item.data_byte, 1'b0, 1'b0);
          end
        end
      end
      PH_POLL: begin
        if (item.operation == OP_REPLY) begin
          if (item.data_byte[0]) begin
            // still busy
            raw[0]  = spi_word(SPI_RDSR, 1'b0, 1'b0);
            raw[1]  = spi_word(SPI_DUMMY, 1'b1, 1'b1);
            res_cnt = CNT_W'(2);
          end else if (ctl.active_command == CMD_PROG && ctl.bytes_left != '0) begin
            ctl_nxt.page_address = next_page;
            ctl_nxt.phase        = PH_PROG;
            page_fill_nxt        = '0;
            raw[0]  = spi_word(SPI_WREN, 1'b1, 1'b0);
            raw[1]  = spi_word(SPI_PP, 1'b0, 1'b0);
            raw[2]  = spi_word(next_page[23:16], 1'b0, 1'b0);
            raw[3]  = spi_word(next_page[15:8], 1'b0, 1'b0);
            raw[4]  = spi_word(next_page[7:0], 1'b0, 1'b0);
            res_cnt = CNT_W'(5);
          end else begin
            raw[0]        = mark_word(KIND_DONE, 8'h00);
            ctl_nxt.phase = PH_IDLE;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      results[i]      = raw[i];
      results[i].last = (CNT_W'(i) == res_cnt - CNT_W'(1));
    end
  end

endmodule

[hdl/spi_flash_command_sequencer_core.sv]
// Throughput: one result per cycle while the output is ready; a word producing
// k results (1 to 7) keeps the next word in the input register while they drain,
// single-result words flow at one per cycle while the output is ready.
// The output run buffer is the limit: it drains one result word per ready cycle.
// Reset (rst_n low, synchronous) empties both stages and returns to idle.
// ---------------------------------------------------------------------------
// spi_flash_command_sequencer_core
// Byte-level SPI NOR command sequencer: input register, decode, result run
// buffer drained one word per cycle while the output is ready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spi_flash_command_sequencer_core #(
  parameter int PAGE_BYTES   = 256,
  parameter int ADDRESS_BITS = 24
) (
  input logic        clk,
  input logic        rst_n,
  sfcs_in_if.sink    in_ch,
  sfcs_out_if.source out_ch
);
  import sfcs_pkg::*;

  localparam int PFW = $clog2(PAGE_BYTES) + 1;

  // input register
  logic           s1_valid_r;
  item_t          s1_item_r;

  // sequencer state
  ctl_t           ctl_r;
  logic [PFW-1:0] page_fill_r;

  // result run buffer
  res_t             res_buf_r [MAX_RES];
  logic             buf_valid_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] idx_r;

  ctl_t             ctl_nxt;
  logic [PFW-1:0]   page_fill_nxt;
  res_t             results [MAX_RES];
  logic [CNT_W-1:0] res_cnt;

  res_t cur;
  logic take;
  logic done_take;
  logic load;
  logic in_take;

  sfcs_step #(
    .PAGE_BYTES   (PAGE_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS),
    .PFW          (PFW)
  ) u_step (
    .item          (s1_item_r),
    .ctl           (ctl_r),
    .page_fill     (page_fill_r),
    .ctl_nxt       (ctl_nxt),
    .page_fill_nxt (page_fill_nxt),
    .results       (results),
    .res_cnt       (res_cnt)
  );

  assign cur       = res_buf_r[idx_r];
  assign take      = buf_valid_r && out_ch.ready;
  assign done_take = take && cur.last;
  assign load      = s1_valid_r && (!buf_valid_r || done_take);
  assign in_take   = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !s1_valid_r || load;

  assign out_ch.valid          = buf_valid_r;
  assign out_ch.kind           = cur.kind;
  assign out_ch.byte_value     = cur.byte_value;
  assign out_ch.release_select = cur.release_select;
  assign out_ch.wants_reply    = cur.wants_reply;
  assign out_ch.last           = cur.last;

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.operation <= in_ch.operation;
      s1_item_r.address   <= in_ch.address;
      s1_item_r.length    <= in_ch.length;
      s1_item_r.data_byte <= in_ch.data_byte;
    end
    if (load) begin
      res_buf_r <= results;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      buf_valid_r <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
      ctl_r       <= '{phase: PH_IDLE, active_command: CMD_READ,
                       page_address: '0, bytes_left: '0};
      page_fill_r <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (load) begin
        s1_valid_r <= 1'b0;
      end

      if (load) begin
        buf_valid_r <= 1'b1;
        cnt_r       <= res_cnt;
        idx_r       <= '0;
        ctl_r       <= ctl_nxt;
        page_fill_r <= page_fill_nxt;
      end else if (take) begin
        if (cur.last) begin
          buf_valid_r <= 1'b0;
        end else begin
          idx_r <= idx_r + CNT_W'(1);
        end
      end
    end
  end

  `ASSERT_HOLDS(a_run_bounds, (buf_valid_r |-> (cnt_r != '0 && idx_r < cnt_r)), "run index out of range")
  `ASSERT_HOLDS(a_run_continues, ((take && !cur.last) |=> buf_valid_r), "run cut short")
  `ASSERT_HOLDS(a_done_is_last, ((buf_valid_r && (cur.kind == KIND_DONE || cur.kind == KIND_REJECT)) |-> cur.last), "done or reject not last in run")
  `ASSERT_HOLDS(a_prog_has_bytes, ((ctl_r.phase == PH_PROG) |-> (ctl_r.bytes_left != '0 && page_fill_r < PFW'(PAGE_BYTES))), "program phase with no bytes or full page")
  `ASSERT_NEVER(a_no_load_midrun, (load && buf_valid_r && !done_take), "run overwritten")

endmodule

[bench/sfcs_sequence_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfcs_sequence_checker
// Watches both channels of the command sequencer. Every word accepted on the
// input runs through a local model of the sequencer, and the result words it
// should cause are queued. Each accepted result word is compared field by
// field with the oldest queued one.
// ---------------------------------------------------------------------------
module sfcs_sequence_checker #(
  parameter int PAGE_BYTES   = 256,
  parameter int ADDRESS_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  sfcs_in_if   in_mon,
  sfcs_out_if  out_mon,
  output int   mismatches,
  output int   outstanding,
  output int   words_checked
);
  import sfcs_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDRESS_BITS >= ADDR_W) ? '1 : ADDR_W'((64'd1 << ADDRESS_BITS) - 1);

  // local copy of the sequencer state
  logic [1:0]        seq_phase;
  logic [1:0]        seq_cmd;
  logic [ADDR_W-1:0] run_addr;
  logic [LEN_W-1:0]  bytes_remaining;
  int                run_fill;

  res_t expected_words[$];

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    words_checked = 0;
  end

  task automatic push_word(input logic [1:0] kind, input logic [7:0] val,
                           input logic rel, input logic rep);
    res_t w;
    w.kind           = kind;
    w.byte_value     = val;
    w.release_select = rel;
    w.wants_reply    = rep;
    w.last           = 1'b0;
    expected_words.push_back(w);
  endtask

  task automatic push_address(input logic [ADDR_W-1:0] a, input logic rel_last);
    push_word(KIND_SPI, a[23:16], 1'b0, 1'b0);
    push_word(KIND_SPI, a[15:8], 1'b0, 1'b0);
    push_word(KIND_SPI, a[7:0], rel_last, 1'b0);
  endtask

  // read-status opcode, then a dummy byte whose reply carries the status
  task automatic push_poll();
    push_word(KIND_SPI, SPI_RDSR, 1'b0, 1'b0);
    push_word(KIND_SPI, SPI_DUMMY, 1'b1, 1'b1);
  endtask

  task automatic open_page_run();
    push_word(KIND_SPI, SPI_WREN, 1'b1, 1'b0);
    push_word(KIND_SPI, SPI_PP, 1'b0, 1'b0);
    push_address(run_addr, 1'b0);
    run_fill  = 0;
    seq_phase = PH_PROG;
  endtask

  task automatic sequence_command(input item_t w);
    logic [ADDR_W-1:0] a;
    res_t              tail;
    a = w.address & ADDR_MASK;
    if (seq_phase == PH_IDLE && w.operation == OP_READ) begin
      seq_cmd = CMD_READ;
      push_word(KIND_SPI, SPI_READ, 1'b0, 1'b0);
      push_address(a, w.length == '0);
      if (w.length == '0) begin
        push_word(KIND_DONE, 8'h00, 1'b0, 1'b0);
      end else begin
        bytes_remaining = w.length;
        push_word(KIND_SPI, SPI_DUMMY, w.length == LEN_W'(1), 1'b1);
        seq_phase = PH_READ;
      end
    end else if (seq_phase == PH_IDLE && w.operation == OP_PROG) begin
      seq_cmd = CMD_PROG;
      if (w.length == '0) begin
        push_word(KIND_DONE, 8'h00, 1'b0, 1'b0);
      end else begin
        run_addr        = a;
        bytes_remaining = w.length;
        open_page_run();
      end
    end else if (seq_phase == PH_IDLE && w.operation == OP_SECT) begin
      seq_cmd = CMD_SECT;
      push_word(KIND_SPI, SPI_WREN, 1'b1, 1'b0);
      push_word(KIND_SPI, SPI_SE, 1'b0, 1'b0);
      push_address(a, 1'b1);
      push_poll();
      seq_phase = PH_POLL;
    end else if (seq_phase == PH_IDLE && w.operation == OP_CHIP) begin
      seq_cmd = CMD_CHIP;
      push_word(KIND_SPI, SPI_WREN, 1'b1, 1'b0);
      push_word(KIND_SPI, SPI_CE, 1'b1, 1'b0);
      push_poll();
      seq_phase = PH_POLL;
    end else if (seq_phase == PH_READ && w.operation == OP_REPLY) begin
      push_word(KIND_DATA, w.data_byte, 1'b0, 1'b0);
      bytes_remaining = bytes_remaining - 1'b1;
      if (bytes_remaining != '0) begin
        push_word(KIND_SPI, SPI_DUMMY, bytes_remaining == LEN_W'(1), 1'b1);
      end else begin
        push_word(KIND_DONE, 8'h00, 1'b0, 1'b0);
        seq_phase = PH_IDLE;
      end
    end else if (seq_phase == PH_PROG && w.operation == OP_WRITE) begin
      run_fill++;
      bytes_remaining = bytes_remaining - 1'b1;
      // page full or data exhausted: close the run and poll
      if (run_fill >= PAGE_BYTES || bytes_remaining == '0) begin
        push_word(KIND_SPI, w.data_byte, 1'b1, 1'b0);
        push_poll();
        seq_phase = PH_POLL;
      end else begin
        push_word(KIND_SPI, w.data_byte, 1'b0, 1'b0);
      end
    end else if (seq_phase == PH_POLL && w.operation == OP_REPLY) begin
      if (w.data_byte[0]) begin
        push_poll();
      end else if (seq_cmd == CMD_PROG && bytes_remaining != '0) begin
        run_addr = (run_addr + ADDR_W'(PAGE_BYTES)) & ADDR_MASK;
        open_page_run();
      end else begin
        push_word(KIND_DONE, 8'h00, 1'b0, 1'b0);
        seq_phase = PH_IDLE;
      end
    end else begin
      push_word(KIND_REJECT, 8'h00, 1'b0, 1'b0);
    end
    tail = expected_words.pop_back();
    tail.last = 1'b1;
    expected_words.push_back(tail);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s wrong: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    item_t w;
    res_t  want;
    if (!rst_n) begin
      seq_phase       = PH_IDLE;
      seq_cmd         = CMD_READ;
      run_addr        = '0;
      bytes_remaining = '0;
      run_fill        = 0;
      expected_words.delete();
    end else begin
      // compare before predicting: a word accepted now cannot answer this edge
      if (out_mon.valid && out_mon.ready) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          $display("%0t: result word with none expected: expected nothing, got kind %0h byte %0h",
                   $time, out_mon.kind, out_mon.byte_value);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("kind", 8'(want.kind), 8'(out_mon.kind));
          check_field("byte_value", want.byte_value, out_mon.byte_value);
          check_field("release_select", 8'(want.release_select), 8'(out_mon.release_select));
          check_field("wants_reply", 8'(want.wants_reply), 8'(out_mon.wants_reply));
          check_field("last", 8'(want.last), 8'(out_mon.last));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        w.operation = in_mon.operation;
        w.address   = in_mon.address;
        w.length    = in_mon.length;
        w.data_byte = in_mon.data_byte;
        sequence_command(w);
      end
    end
    outstanding = expected_words.size();
  end

endmodule

[bench/tb_spi_flash_command_sequencer_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_spi_flash_command_sequencer_core
// Drives the command sequencer with directed corner cases, then with random
// read, program and erase transactions that follow the flash protocol
// (write bytes per page, status replies with random busy polls), salted with
// words that arrive in the wrong phase. The input side sends in bursts, the
// output side stalls on its own pattern and once holds off long enough to
// back the block up. Checking lives in sfcs_sequence_checker.
// ---------------------------------------------------------------------------
module tb_spi_flash_command_sequencer_core;
  import sfcs_pkg::*;

  localparam int PAGE_BYTES    = 256;
  localparam int ADDRESS_BITS  = 24;
  localparam int RANDOM_WORDS  = 450;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 200000;

  // operation codes the block always refuses
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  logic clk;
  logic rst_n;

  sfcs_in_if  in_ch ();
  sfcs_out_if out_ch ();

  int  mismatches;
  int  outstanding;
  int  words_checked;
  int  words_sent = 0;
  int  cycle_count = 0;
  int  burst_left = 4;
  bit  offering = 1'b0;
  bit  long_done = 1'b0;
  int  n_reads = 0;
  int  n_programs = 0;
  int  n_pages = 0;
  int  n_erases = 0;
  int  n_rejects = 0;

  spi_flash_command_sequencer_core #(
    .PAGE_BYTES  (PAGE_BYTES),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  sfcs_sequence_checker #(
    .PAGE_BYTES  (PAGE_BYTES),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) seq_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .words_checked(words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result words outstanding",
               cycle_count, outstanding);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---- word builders ----

  function automatic item_t random_word();
    item_t w;
    w.operation = OP_W'($urandom);
    w.address   = ADDR_W'($urandom);
    w.length    = LEN_W'($urandom);
    w.data_byte = 8'($urandom);
    return w;
  endfunction

  function automatic item_t junk_word(input logic [OP_W-1:0] op);
    item_t w;
    w = random_word();
    w.operation = op;
    n_rejects++;
    return w;
  endfunction

  // something the block must refuse in the given phase
  function automatic item_t wrong_phase_word(input logic [1:0] ph);
    int pick;
    pick = $urandom_range(0, 3);
    if (pick == 0)
      return junk_word($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B);
    else if (ph == PH_IDLE)
      return junk_word($urandom_range(0, 1) ? OP_WRITE : OP_REPLY);
    else if (pick == 1)
      return junk_word(OP_READ + OP_W'($urandom_range(0, int'(OP_CHIP))));
    else
      return junk_word(ph == PH_PROG ? OP_REPLY : OP_WRITE);
  endfunction

  function automatic item_t command_word(input logic [OP_W-1:0] op,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [LEN_W-1:0] len);
    item_t w;
    w = random_word();
    w.operation = op;
    w.address   = addr;
    w.length    = len;
    return w;
  endfunction

  function automatic item_t write_word(input logic [7:0] d);
    item_t w;
    w = random_word();
    w.operation = OP_WRITE;
    w.data_byte = d;
    return w;
  endfunction

  function automatic item_t reply_word(input logic [7:0] d);
    item_t w;
    w = random_word();
    w.operation = OP_REPLY;
    w.data_byte = d;
    return w;
  endfunction

  function automatic int busy_count();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return ADDR_W'(24'hFFFFFF - $urandom_range(0, 255));
    return ADDR_W'($urandom);
  endfunction

  // ---- input side ----

  // Called at a rising edge; returns at the edge that took the word.
  task automatic offer(input item_t w);
    in_ch.valid     <= 1'b1;
    in_ch.operation <= w.operation;
    in_ch.address   <= w.address;
    in_ch.length    <= w.length;
    in_ch.data_byte <= w.data_byte;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 10);
    end
  endtask

  task automatic sprinkle(input logic [1:0] ph);
    if ($urandom_range(0, 99) < 8) offer(wrong_phase_word(ph));
  endtask

  task automatic run_poll(input int busy);
    repeat (busy) begin
      sprinkle(PH_POLL);
      offer(reply_word(8'($urandom) | 8'h01));
    end
    sprinkle(PH_POLL);
    offer(reply_word(8'($urandom) & 8'hFE));
  endtask

  task automatic run_read(input logic [ADDR_W-1:0] addr, input int len);
    n_reads++;
    offer(command_word(OP_READ, addr, LEN_W'(len)));
    repeat (len) begin
      sprinkle(PH_READ);
      offer(reply_word(8'($urandom)));
    end
  endtask

  task automatic run_program(input logic [ADDR_W-1:0] addr, input int len);
    int remaining;
    int chunk;
    n_programs++;
    offer(command_word(OP_PROG, addr, LEN_W'(len)));
    remaining = len;
    while (remaining > 0) begin
      chunk = (remaining > PAGE_BYTES) ? PAGE_BYTES : remaining;
      repeat (chunk) begin
        sprinkle(PH_PROG);
        offer(write_word(8'($urandom)));
      end
      n_pages++;
      run_poll(busy_count());
      remaining -= chunk;
    end
  endtask

  task automatic run_erase(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
    n_erases++;
    offer(command_word(op, addr, LEN_W'($urandom)));
    run_poll(busy_count());
  endtask

  initial begin : stimulus
    int pick;
    int len;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= '0;
    in_ch.address   <= '0;
    in_ch.length    <= '0;
    in_ch.data_byte <= '0;
    rst_n           <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: bad words while idle
    offer(junk_word(OP_SPARE_A));
    offer(junk_word(OP_SPARE_B));
    offer(junk_word(OP_WRITE));
    offer(junk_word(OP_REPLY));
    // zero-length read, one-byte read at the top address, zero-length program
    run_read('0, 0);
    run_read('1, 1);
    run_program(24'h123456, 0);
    // sector erase with a command while busy and one busy status
    n_erases++;
    offer(command_word(OP_SECT, '1, '1));
    offer(junk_word(OP_PROG));
    offer(reply_word(8'hFF));
    offer(reply_word(8'h00));
    // chip erase with a write byte while polling
    n_erases++;
    offer(command_word(OP_CHIP, '0, '0));
    offer(junk_word(OP_WRITE));
    offer(reply_word(8'hFE));
    // two-byte program, data extremes, a reply while taking write bytes
    n_programs++;
    n_pages++;
    offer(command_word(OP_PROG, 24'hABCDEF, LEN_W'(2)));
    offer(write_word(8'h00));
    offer(junk_word(OP_REPLY));
    offer(write_word(8'hFF));
    offer(reply_word(8'h00));

    // random transactions
    while (words_sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 19);
      if (pick < 7) begin
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        run_read(pick_address(), len);
      end else if (pick < 13) begin
        if (!long_done) begin
          // crosses a page and wraps the address space
          long_done = 1'b1;
          run_program(24'hFFFF00 + ADDR_W'($urandom_range(0, 255)),
                      $urandom_range(PAGE_BYTES + 1, PAGE_BYTES + 14));
        end else begin
          pick = $urandom_range(0, 19);
          len  = (pick == 0) ? 0 :
                 (pick == 1) ? $urandom_range(PAGE_BYTES, PAGE_BYTES + 14) :
                               $urandom_range(1, 12);
          run_program(pick_address(), len);
        end
      end else if (pick < 17) begin
        run_erase(OP_SECT, pick_address());
      end else if (pick < 19) begin
        run_erase(OP_CHIP, pick_address());
      end else begin
        offer(wrong_phase_word(PH_IDLE));
      end
    end

    // read with the widest length: left running at the end
    n_reads++;
    offer(command_word(OP_READ, ADDR_W'($urandom), '1));
    repeat (3) offer(reply_word(8'($urandom)));

    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words: %0d reads, %0d programs (%0d pages), %0d erases, %0d refused",
             words_sent, n_reads, n_programs, n_pages, n_erases, n_rejects);
    $display("checked %0d result words in %0d cycles", words_checked, cycle_count);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // ---- output side: stall patterns, plus one long hold-off ----
  initial begin : receiver
    int         mode;
    int         span;
    logic [7:0] mask;
    bit         held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && words_sent >= 150) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(16, 64);
        mask = 8'($urandom);
        for (int i = 0; i < span; i++) begin
          case (mode)
            0: begin
              out_ch.ready <= 1'b1;
            end
            1: begin
              out_ch.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
              out_ch.ready <= mask[i % 8];
            end
          endcase
          @(posedge clk);
        end
      end
    end
  end

endmodule
